// File: hw/rtl/eff_pkg.sv
// Shared types and codes for the exterior flood-fill classifier.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package eff_pkg;

  // Cell kinds as loaded
  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_STAR  = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  // Result classes
  localparam logic [1:0] CLASS_DOT      = 2'd0;
  localparam logic [1:0] CLASS_ADJACENT = 2'd1;
  localparam logic [1:0] CLASS_ISOLATED = 2'd2;
  localparam logic [1:0] CLASS_ENCLOSED = 2'd3;

  // Operations of an input transaction
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Register indexes (bit 2 of the byte address)
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Per-cell marks kept by the fill
  typedef struct packed {
    logic adj;
    logic vis;
  } mark_t;

endpackage

`default_nettype wire

// File: hw/rtl/exterior_flood_fill_classifier.sv
// Exterior flood-fill classifier: top level with cell, mark and queue memories.
// Depends on eff_pkg.
`default_nettype none

// A fetch makes five reads of the mark memory (one
// port). A config write makes the next transaction first re-derive row and
// column of both pointers with a restoring divider. The last_cell load starts
// a clearing pass over the mark memory, then the fill, limited by the single
// read port of the mark memory. The same clearing pass runs after reset.
// busy is high for all of this; results come as a one-cycle out_valid strobe
// and cannot be stalled.
module exterior_flood_fill_classifier #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transactions
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [1:0]  in_cell_kind,
  input  wire logic        in_last_cell,
  // results
  output logic             out_valid,
  output logic [1:0]       out_class_code,
  output logic             out_row_end,
  output logic             out_last_result,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int RW    = $clog2(MAX_ROWS + 2);
  localparam int CW    = $clog2(MAX_COLS + 2);
  localparam int AW    = RW + CW;
  localparam int MDEP  = 1 << AW;
  localparam int QDEP  = (MAX_ROWS + 2) * (MAX_COLS + 2);
  localparam int QIW   = $clog2(QDEP);
  localparam int QCW   = $clog2(QDEP + 1);
  localparam int PW    = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int DCW   = $clog2(PW + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_LOAD, ST_SEED, ST_POP, ST_QWAIT,
    ST_NB_RD, ST_NB_WR, ST_F_ADJ, ST_F_RD, ST_F_OUT
  } state_t;

  state_t state_r;

  logic [6:0] rows_r, cols_r;
  logic       stale_r, fill_r;
  logic       op_r, last_r;
  logic [1:0] kind_r;

  logic [PW-1:0] ld_ptr_r, rd_ptr_r;
  logic [RW-1:0] ld_row_r, rd_row_r;
  logic [CW-1:0] ld_col_r, rd_col_r;

  logic [AW-1:0]  clr_r;
  logic [QCW-1:0] head_r, tail_r;
  logic [RW-1:0]  cur_row_r;
  logic [CW-1:0]  cur_col_r;
  logic [1:0]     nb_r;
  logic [2:0]     step_r;
  logic [1:0]     ckind_r;
  logic           cadj_r;
  logic [2:0]     nvis_r;

  logic [PW-1:0]  div_num_r, div_quo_r;
  logic [CW:0]    div_rem_r;
  logic [DCW-1:0] div_cnt_r;
  logic           div_tgt_r;

  logic [1:0] class_r;
  logic       row_end_r, last_res_r, out_valid_r;

  // Saturated geometry
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic [PW-1:0] total;

  always_comb begin
    if (rows_r == 7'd0) nr = RW'(1);
    else if (int'(rows_r) > MAX_ROWS) nr = RW'(MAX_ROWS);
    else nr = RW'(rows_r);
    if (cols_r == 7'd0) nc = CW'(1);
    else if (int'(cols_r) > MAX_COLS) nc = CW'(MAX_COLS);
    else nc = CW'(cols_r);
  end

  assign total = PW'(nr) * PW'(nc);

  // Config port
  localparam logic REG_COLS_IDX = eff_pkg::REG_COLS;
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COLS_IDX) ? {25'd0, cols_r} : {25'd0, rows_r};

  // Memories
  logic [1:0]      cell_mem [MDEP];
  eff_pkg::mark_t  mark_mem [MDEP];
  logic [AW-1:0]   queue_mem [QDEP];

  logic            cell_we, mark_we, q_we;
  logic [AW-1:0]   cell_wa, cell_ra, mark_wa, mark_ra, q_wd;
  eff_pkg::mark_t  mark_wd, mark_rd;
  logic [1:0]      cell_rd;
  logic [AW-1:0]   q_rd;

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= kind_r;
    cell_rd <= cell_mem[cell_ra];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd <= mark_mem[mark_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[tail_r[QIW-1:0]] <= q_wd;
    q_rd <= queue_mem[head_r[QIW-1:0]];
  end

  // Neighbor of the cell being expanded: up, left, down, right
  logic [RW-1:0] nb_row;
  logic [CW-1:0] nb_col;
  logic          nb_ok, nb_border, nb_open;

  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    nb_ok  = 1'b0;
    unique case (nb_r)
      2'd0: begin nb_row = cur_row_r - RW'(1); nb_ok = (cur_row_r != '0); end
      2'd1: begin nb_col = cur_col_r - CW'(1); nb_ok = (cur_col_r != '0); end
      2'd2: begin nb_row = cur_row_r + RW'(1); nb_ok = (cur_row_r <= nr); end
      default: begin nb_col = cur_col_r + CW'(1); nb_ok = (cur_col_r <= nc); end
    endcase
  end

  assign nb_border = (nb_row == '0) || (nb_col == '0) || (nb_row > nr) || (nb_col > nc);
  assign nb_open   = nb_border || (cell_rd == eff_pkg::KIND_OPEN);

  // Fetch cell in bordered coordinates and its read address per step
  logic [RW-1:0] f_row;
  logic [CW-1:0] f_col;
  logic [AW-1:0] f_addr;

  assign f_row = rd_row_r + RW'(1);
  assign f_col = rd_col_r + CW'(1);

  always_comb begin
    unique case (step_r)
      3'd1:    f_addr = {f_row - RW'(1), f_col};
      3'd2:    f_addr = {f_row, f_col - CW'(1)};
      3'd3:    f_addr = {f_row + RW'(1), f_col};
      3'd4:    f_addr = {f_row, f_col + CW'(1)};
      default: f_addr = {f_row, f_col};
    endcase
  end

  logic ld_ok;
  assign ld_ok = (ld_ptr_r < total);

  // Memory port steering
  always_comb begin
    cell_we = (state_r == ST_LOAD) && ld_ok;
    cell_wa = {ld_row_r + RW'(1), ld_col_r + CW'(1)};
    cell_ra = (state_r == ST_F_RD) ? f_addr : {nb_row, nb_col};
    mark_ra = (state_r == ST_F_RD) ? f_addr : {nb_row, nb_col};
    mark_we = 1'b0;
    mark_wa = {nb_row, nb_col};
    mark_wd = '0;
    q_we    = 1'b0;
    q_wd    = {nb_row, nb_col};
    unique case (state_r)
      ST_CLEAR: begin
        mark_we = 1'b1;
        mark_wa = clr_r;
      end
      ST_SEED: begin
        mark_we     = 1'b1;
        mark_wa     = '0;
        mark_wd.vis = 1'b1;
        q_we        = 1'b1;
        q_wd        = '0;
      end
      ST_NB_WR: begin
        if (nb_open) begin
          mark_we     = !mark_rd.vis;
          mark_wd.vis = 1'b1;
          q_we        = !mark_rd.vis;
        end else begin
          mark_we     = 1'b1;
          mark_wd.adj = 1'b1;
          mark_wd.vis = mark_rd.vis;
        end
      end
      default: ;
    endcase
  end

  // Divider step
  logic [CW:0]   div_sh;
  logic          div_ge;
  logic [CW:0]   div_rem_nxt;
  logic [PW-1:0] div_quo_nxt;

  assign div_sh      = {div_rem_r[CW-1:0], div_num_r[PW-1]};
  assign div_ge      = (div_sh >= {1'b0, nc});
  assign div_rem_nxt = div_ge ? div_sh - {1'b0, nc} : div_sh;
  assign div_quo_nxt = PW'({div_quo_r, div_ge});

  // Fetch classification
  logic          all_vis;
  logic [1:0]    class_nxt;
  assign all_vis = mark_rd.vis && (&nvis_r);

  always_comb begin
    if (ckind_r == eff_pkg::KIND_STAR) begin
      if (cadj_r) class_nxt = all_vis ? eff_pkg::CLASS_ENCLOSED : eff_pkg::CLASS_ADJACENT;
      else class_nxt = eff_pkg::CLASS_ISOLATED;
    end else begin
      class_nxt = cadj_r ? eff_pkg::CLASS_ADJACENT : eff_pkg::CLASS_DOT;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      rows_r      <= 7'd1;
      cols_r      <= 7'd1;
      stale_r     <= 1'b0;
      fill_r      <= 1'b0;
      ld_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      rd_row_r    <= '0;
      rd_col_r    <= '0;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_F_OUT);
      if (cfg_wr) begin
        if (paddr[2] == REG_COLS_IDX) cols_r <= pwdata[6:0];
        else rows_r <= pwdata[6:0];
        stale_r <= 1'b1;
      end
      unique case (state_r)
        // sweep the mark memory
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == '1) state_r <= fill_r ? ST_SEED : ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            op_r   <= in_op;
            kind_r <= in_cell_kind;
            last_r <= in_last_cell;
            if (stale_r) begin
              state_r   <= ST_DIV;
              div_tgt_r <= 1'b0;
              div_num_r <= ld_ptr_r;
              div_rem_r <= '0;
              div_quo_r <= '0;
              div_cnt_r <= '0;
            end else begin
              state_r <= (in_op == eff_pkg::OP_FETCH) ? ST_F_ADJ : ST_LOAD;
            end
          end
        end
        // re-derive row and column of a pointer
        ST_DIV: begin
          if (div_cnt_r == DCW'(PW - 1)) begin
            div_cnt_r <= '0;
            div_rem_r <= '0;
            div_quo_r <= '0;
            if (!div_tgt_r) begin
              ld_row_r  <= RW'(div_quo_nxt);
              ld_col_r  <= CW'(div_rem_nxt);
              div_tgt_r <= 1'b1;
              div_num_r <= rd_ptr_r;
            end else begin
              rd_row_r <= RW'(div_quo_nxt);
              rd_col_r <= CW'(div_rem_nxt);
              stale_r  <= 1'b0;
              state_r  <= (op_r == eff_pkg::OP_FETCH) ? ST_F_ADJ : ST_LOAD;
            end
          end else begin
            div_num_r <= div_num_r << 1;
            div_rem_r <= div_rem_nxt;
            div_quo_r <= div_quo_nxt;
            div_cnt_r <= div_cnt_r + DCW'(1);
          end
        end
        ST_LOAD: begin
          if (last_r) begin
            ld_ptr_r <= '0;
            ld_row_r <= '0;
            ld_col_r <= '0;
            rd_ptr_r <= '0;
            rd_row_r <= '0;
            rd_col_r <= '0;
            head_r   <= '0;
            tail_r   <= '0;
            stale_r  <= 1'b0;
            fill_r   <= 1'b1;
            clr_r    <= '0;
            state_r  <= ST_CLEAR;
          end else begin
            if (ld_ok) begin
              ld_ptr_r <= ld_ptr_r + PW'(1);
              if (ld_col_r + CW'(1) == nc) begin
                ld_col_r <= '0;
                ld_row_r <= ld_row_r + RW'(1);
              end else begin
                ld_col_r <= ld_col_r + CW'(1);
              end
            end
            state_r <= ST_IDLE;
          end
        end
        // push the border corner
        ST_SEED: begin
          fill_r  <= 1'b0;
          head_r  <= '0;
          tail_r  <= QCW'(1);
          state_r <= ST_POP;
        end
        ST_POP: begin
          if (head_r == tail_r) begin
            state_r <= ST_IDLE;
          end else begin
            head_r  <= head_r + QCW'(1);
            state_r <= ST_QWAIT;
          end
        end
        ST_QWAIT: begin
          cur_row_r <= q_rd[AW-1:CW];
          cur_col_r <= q_rd[CW-1:0];
          nb_r      <= 2'd0;
          state_r   <= ST_NB_RD;
        end
        ST_NB_RD: begin
          if (nb_ok) begin
            state_r <= ST_NB_WR;
          end else begin
            nb_r <= nb_r + 2'd1;
            if (nb_r == 2'd3) state_r <= ST_POP;
          end
        end
        ST_NB_WR: begin
          if (q_we) tail_r <= tail_r + QCW'(1);
          nb_r    <= nb_r + 2'd1;
          state_r <= (nb_r == 2'd3) ? ST_POP : ST_NB_RD;
        end
        // fetch: wrap a pointer left beyond the grid
        ST_F_ADJ: begin
          if (rd_ptr_r >= total) begin
            rd_ptr_r <= '0;
            rd_row_r <= '0;
            rd_col_r <= '0;
          end
          step_r  <= 3'd0;
          state_r <= ST_F_RD;
        end
        // center then four neighbors, one read per cycle
        ST_F_RD: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd1) begin
            ckind_r <= cell_rd;
            cadj_r  <= mark_rd.adj;
          end else if (step_r != 3'd0) begin
            nvis_r[2'(step_r - 3'd2)] <= mark_rd.vis;
          end
          if (step_r == 3'd4) state_r <= ST_F_OUT;
        end
        ST_F_OUT: begin
          class_r     <= class_nxt;
          row_end_r   <= (rd_col_r + CW'(1) == nc);
          last_res_r  <= (rd_ptr_r + PW'(1) == total);
          if (rd_ptr_r + PW'(1) == total) begin
            rd_ptr_r <= '0;
            rd_row_r <= '0;
            rd_col_r <= '0;
          end else begin
            rd_ptr_r <= rd_ptr_r + PW'(1);
            if (rd_col_r + CW'(1) == nc) begin
              rd_col_r <= '0;
              rd_row_r <= rd_row_r + RW'(1);
            end else begin
              rd_col_r <= rd_col_r + CW'(1);
            end
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_class_code  = class_r;
  assign out_row_end     = row_end_r;
  assign out_last_result = last_res_r;

endmodule

`default_nettype wire

// File: hw/rtl/eff_checker.sv
// Port-level checks for the exterior flood-fill classifier, bound to the top.
// Depends on exterior_flood_fill_classifier and eff_pkg.
`default_nettype none

module eff_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       in_op,
  input wire logic       out_valid,
  input wire logic       out_last_result,
  input wire logic       out_row_end,
  input wire logic       pready
);

  // an accepted transaction always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result is a single-cycle strobe
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result follows only a fetch transaction
  a_fetch_only: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_op == eff_pkg::OP_LOAD) |=> !out_valid ##1 !out_valid)
    else $error("result after a load transaction");

  // grid end is also a row end
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> out_row_end)
    else $error("final result not flagged as row end");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("config port not ready");

endmodule

bind exterior_flood_fill_classifier eff_checker u_eff_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_op(in_op),
  .out_valid(out_valid), .out_last_result(out_last_result),
  .out_row_end(out_row_end), .pready(pready)
);

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for exterior_flood_fill_classifier.
// Loads random and hand-built grids, mirrors the border fill in a local model and
// checks every fetched class. Depends on eff_pkg and the top level RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int MAXR = 64;
  localparam int MAXC = 64;
  localparam int GW = MAXC + 2;
  localparam int GCELLS = (MAXR + 2) * (MAXC + 2);
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic [1:0] cls;
    logic       row_end;
    logic       last;
  } class_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_op;
  logic [1:0]  in_cell_kind;
  logic        in_last_cell;
  logic        out_valid;
  logic [1:0]  out_class_code;
  logic        out_row_end;
  logic        out_last_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  exterior_flood_fill_classifier dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_cell_kind(in_cell_kind), .in_last_cell(in_last_cell),
    .out_valid(out_valid), .out_class_code(out_class_code),
    .out_row_end(out_row_end), .out_last_result(out_last_result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Local copy of the block state
  logic [6:0] rows_reg, cols_reg;
  logic [1:0] kind_mem [MAXR*MAXC];
  bit         vis_map [GCELLS];
  bit         adj_map [GCELLS];
  int         bfs_q [GCELLS];
  int         load_ptr, read_ptr;
  class_result_t class_queue[$];
  int         err_count;
  int         cycle_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int eff_rows();
    if (rows_reg < 1) return 1;
    if (rows_reg > MAXR) return MAXR;
    return rows_reg;
  endfunction

  function automatic int eff_cols();
    if (cols_reg < 1) return 1;
    if (cols_reg > MAXC) return MAXC;
    return cols_reg;
  endfunction

  // Kind of a bordered cell; the frame is open
  function automatic logic [1:0] bordered_kind(int r, int c, int nr, int nc);
    if (r == 0 || c == 0 || r > nr || c > nc) return eff_pkg::KIND_OPEN;
    return kind_mem[(r - 1) * MAXC + (c - 1)];
  endfunction

  function automatic void touch_cell(int r, int c, int nr, int nc, inout int tail);
    int p;
    p = r * GW + c;
    if (bordered_kind(r, c, nr, nc) == eff_pkg::KIND_OPEN) begin
      if (!vis_map[p]) begin
        vis_map[p] = 1;
        bfs_q[tail] = p;
        tail++;
      end
    end else begin
      adj_map[p] = 1;
    end
  endfunction

  // Breadth-first fill from the top-left border corner
  function automatic void flood_from_border();
    int nr, nc, head, tail, p, r, c;
    nr = eff_rows();
    nc = eff_cols();
    for (int i = 0; i < GCELLS; i++) begin
      vis_map[i] = 0;
      adj_map[i] = 0;
    end
    head = 0;
    tail = 1;
    vis_map[0] = 1;
    bfs_q[0] = 0;
    while (head < tail) begin
      p = bfs_q[head];
      head++;
      r = p / GW;
      c = p % GW;
      if (r > 0) touch_cell(r - 1, c, nr, nc, tail);
      if (c > 0) touch_cell(r, c - 1, nr, nc, tail);
      if (r + 1 < nr + 2) touch_cell(r + 1, c, nr, nc, tail);
      if (c + 1 < nc + 2) touch_cell(r, c + 1, nr, nc, tail);
    end
  endfunction

  // Advance the local state by one accepted transaction
  function automatic void classify_transaction(logic op, logic [1:0] kind, logic last);
    int nr, nc, total, r, c, p;
    class_result_t res;
    nr = eff_rows();
    nc = eff_cols();
    total = nr * nc;
    if (op == eff_pkg::OP_LOAD) begin
      if (load_ptr < total) begin
        kind_mem[(load_ptr / nc) * MAXC + (load_ptr % nc)] = kind;
        load_ptr++;
      end
      if (last) begin
        flood_from_border();
        load_ptr = 0;
        read_ptr = 0;
      end
    end else begin
      if (read_ptr >= total) read_ptr = 0;
      r = read_ptr / nc + 1;
      c = read_ptr % nc + 1;
      p = r * GW + c;
      if (bordered_kind(r, c, nr, nc) == eff_pkg::KIND_STAR) begin
        if (adj_map[p])
          res.cls = (vis_map[p - GW] && vis_map[p - 1] && vis_map[p + GW] && vis_map[p + 1])
                    ? eff_pkg::CLASS_ENCLOSED : eff_pkg::CLASS_ADJACENT;
        else
          res.cls = eff_pkg::CLASS_ISOLATED;
      end else begin
        res.cls = adj_map[p] ? eff_pkg::CLASS_ADJACENT : eff_pkg::CLASS_DOT;
      end
      res.row_end = (c == nc);
      res.last = (read_ptr + 1 == total);
      read_ptr = (read_ptr + 1 == total) ? 0 : read_ptr + 1;
      class_queue.push_back(res);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    class_result_t want;
    if (rst_n && out_valid) begin
      if (class_queue.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = class_queue.pop_front();
        if (out_class_code !== want.cls) report_mismatch("class_code", out_class_code, want.cls);
        if (out_row_end !== want.row_end) report_mismatch("row_end", out_row_end, want.row_end);
        if (out_last_result !== want.last)
          report_mismatch("last_result", out_last_result, want.last);
      end
    end
  end

  function automatic int rand_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [1:0] rand_kind();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return eff_pkg::KIND_OPEN;
    if (k < 75) return eff_pkg::KIND_STAR;
    if (k < 94) return eff_pkg::KIND_OTHER;
    return 2'd3;
  endfunction

  // Send one transaction; called at a rising edge
  task automatic send_item(logic op, logic [1:0] kind, logic last, int gap);
    start <= 1'b1;
    in_op <= op;
    in_cell_kind <= kind;
    in_last_cell <= last;
    do @(posedge clk); while (busy);
    classify_transaction(op, kind, last);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all results and let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (class_queue.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == eff_pkg::REG_ROWS) rows_reg = value[6:0];
    else cols_reg = value[6:0];
    @(posedge clk);
  endtask

  task automatic set_geometry(int r, int c);
    wait_idle();
    write_reg(eff_pkg::REG_ROWS, r);
    write_reg(eff_pkg::REG_COLS, c);
  endtask

  // Fill the whole grid with random kinds, fill starts on the last cell
  task automatic load_random_grid(bit burst);
    int total;
    total = eff_rows() * eff_cols();
    for (int i = 0; i < total; i++)
      send_item(eff_pkg::OP_LOAD, rand_kind(), i == total - 1, burst ? 0 : rand_gap());
  endtask

  task automatic fetch_n(int n);
    for (int i = 0; i < n; i++) send_item(eff_pkg::OP_FETCH, 2'd0, 1'b0, rand_gap());
  endtask

  // Default 1x1 geometry: single star fully surrounded by border
  task automatic test_reset_geometry();
    send_item(eff_pkg::OP_LOAD, eff_pkg::KIND_STAR, 1'b1, 0);
    fetch_n(2);
    send_item(eff_pkg::OP_LOAD, eff_pkg::KIND_OPEN, 1'b1, 1);
    fetch_n(1);
  endtask

  // Star ring around an open center, other obstacles, kind three, extra loads
  task automatic test_directed_shapes();
    logic [1:0] ring [9];
    ring = '{eff_pkg::KIND_STAR, eff_pkg::KIND_STAR, eff_pkg::KIND_STAR,
             eff_pkg::KIND_STAR, eff_pkg::KIND_OPEN, eff_pkg::KIND_OTHER, 2'd3,
             eff_pkg::KIND_STAR, eff_pkg::KIND_STAR};
    set_geometry(3, 3);
    for (int i = 0; i < 9; i++) send_item(eff_pkg::OP_LOAD, ring[i], 1'b0, 0);
    // loads past the end are dropped, the flag still starts the fill
    send_item(eff_pkg::OP_LOAD, eff_pkg::KIND_OTHER, 1'b0, 0);
    send_item(eff_pkg::OP_LOAD, eff_pkg::KIND_OPEN, 1'b1, 2);
    fetch_n(10);
    // overwrite two cells without a new fill, then fetch again
    send_item(eff_pkg::OP_LOAD, eff_pkg::KIND_OPEN, 1'b0, 0);
    send_item(eff_pkg::OP_LOAD, eff_pkg::KIND_STAR, 1'b0, 0);
    fetch_n(9);
    // shrink the grid with both pointers away from zero, then fetch
    set_geometry(2, 3);
    fetch_n(4);
    send_item(eff_pkg::OP_LOAD, eff_pkg::KIND_OPEN, 1'b1, 0);
  endtask

  // Saturation of out-of-range values and the longest single-row and single-column shapes
  task automatic test_extremes();
    set_geometry(0, 127);
    load_random_grid(1);
    fetch_n(70);
    set_geometry(127, 0);
    load_random_grid(1);
    fetch_n(70);
  endtask

  // Random phases on mostly small grids
  task automatic test_random_grids();
    int items, ops, k;
    items = 0;
    while (items < 700) begin
      if ($urandom_range(0, 5) == 0) set_geometry($urandom_range(1, 16), $urandom_range(1, 16));
      else set_geometry($urandom_range(1, 6), $urandom_range(1, 6));
      load_random_grid($urandom_range(0, 3) == 0);
      items += eff_rows() * eff_cols();
      ops = $urandom_range(20, 80);
      for (int i = 0; i < ops; i++) begin
        k = $urandom_range(0, 99);
        if (k < 60) send_item(eff_pkg::OP_FETCH, 2'($urandom), 1'($urandom), rand_gap());
        else if (k < 97) send_item(eff_pkg::OP_LOAD, rand_kind(), 1'b0, rand_gap());
        else send_item(eff_pkg::OP_LOAD, rand_kind(), 1'b1, rand_gap());
        if (k == 50) wait_idle();
      end
      items += ops;
      // return both pointers to zero before the geometry moves
      send_item(eff_pkg::OP_LOAD, rand_kind(), 1'b1, 0);
    end
  endtask

  initial begin
    err_count = 0;
    cycle_count = 0;
    rows_reg = 7'd1;
    cols_reg = 7'd1;
    load_ptr = 0;
    read_ptr = 0;
    for (int i = 0; i < GCELLS; i++) begin
      vis_map[i] = 0;
      adj_map[i] = 0;
    end
    rst_n = 1'b0;
    start = 1'b0;
    in_op = eff_pkg::OP_LOAD;
    in_cell_kind = eff_pkg::KIND_OPEN;
    in_last_cell = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_geometry();
    test_directed_shapes();
    test_extremes();
    test_random_grids();

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0 && class_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
